// ===== rtl/core/ising_metropolis_lattice_update_core_assert.svh =====
// assertion macros for the ising lattice update core
`ifndef ISING_METROPOLIS_LATTICE_UPDATE_CORE_ASSERT_SVH
`define ISING_METROPOLIS_LATTICE_UPDATE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define IMLU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imlu assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define IMLU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imlu assertion failed");

`endif

// ===== rtl/core/imlu_pkg.sv =====
// shared constants and types of the ising lattice update core
package imlu_pkg;

  localparam int MAX_SIDE_DEF = 64;

  localparam int MODE_W     = 2;
  localparam int SITE_W     = 12;
  localparam int RND_W      = 32;
  localparam int DE_W       = 5;
  localparam int EN_W       = 15;
  localparam int MAG_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_SIDE_W = 7;
  localparam int SIDE_MIN   = 3;
  localparam int Q_DEPTH    = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR4 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR8 = 2'd2;

  localparam logic [CFG_SIDE_W-1:0] SIDE_RST = 7'd64;
  localparam logic [RND_W-1:0]      THR4_RST = 32'd1346412118;
  localparam logic [RND_W-1:0]      THR8_RST = 32'd422081899;

  localparam logic signed [DE_W-1:0] DE_FOUR  = 5'sd4;
  localparam logic signed [DE_W-1:0] DE_EIGHT = 5'sd8;

  // work class of a queued item
  typedef enum logic [1:0] {
    K_NULL,
    K_LOAD,
    K_UPDATE,
    K_MEASURE
  } kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/imlu_ram.sv =====
// generic single-port ram with registered read
module imlu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/imlu_queue.sv =====
// short fifo between the front and the back
module imlu_queue import imlu_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH = Q_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output q_stat_t           q_stat
);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push_ok, pop_ok;

  assign push_ok = push && (cnt_r != CNT_W'(DEPTH));
  assign pop_ok  = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

// ===== rtl/core/imlu_front.sv =====
// front: takes items, classifies them and splits the site into row and column
module imlu_front import imlu_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int RC_W   = $clog2(MAX_SIDE),
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE),
  localparam int WW     = SIDE_W + RC_W,
  localparam int CNT_W  = $clog2(RC_W),
  localparam int ENT_W  = 2 + ADDR_W + 2 * RC_W + 1 + RND_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [SITE_W-1:0] in_site,
  input  logic              in_spin_bit,
  input  logic [RND_W-1:0]  in_random_word,
  input  logic [SIDE_W-1:0] side_eff,
  input  q_stat_t           q_stat,
  output logic              push,
  output logic [ENT_W-1:0]  push_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fst_t;

  fst_t               st_r, st_nxt;
  kind_t              kind_r, kind_nxt, kind_c;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               spin_r, spin_nxt;
  logic [RND_W-1:0]   rnd_r, rnd_nxt;
  logic [WW-1:0]      rem_r, rem_nxt;
  logic [WW-1:0]      dvs_r, dvs_nxt;
  logic [RC_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2*SIDE_W-1:0] nsites;
  logic               in_rng;

  assign nsites = side_eff * side_eff;
  assign in_rng = 32'(in_site) < 32'(nsites);

  always_comb begin
    if (in_mode == MODE_LOAD && in_rng) begin
      kind_c = K_LOAD;
    end else if (in_mode == MODE_UPDATE && in_rng) begin
      kind_c = K_UPDATE;
    end else if (in_mode == MODE_MEASURE) begin
      kind_c = K_MEASURE;
    end else begin
      kind_c = K_NULL;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    kind_nxt = kind_r;
    addr_nxt = addr_r;
    spin_nxt = spin_r;
    rnd_nxt  = rnd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    unique case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          kind_nxt = kind_c;
          addr_nxt = ADDR_W'(in_site);
          spin_nxt = in_spin_bit;
          rnd_nxt  = in_random_word;
          rem_nxt  = WW'(in_site);
          dvs_nxt  = WW'(side_eff) << (RC_W - 1);
          quo_nxt  = '0;
          cnt_nxt  = '0;
          st_nxt   = (kind_c == K_UPDATE) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        // one quotient bit per cycle, msb first
        if (rem_r >= dvs_r) begin
          rem_nxt = rem_r - dvs_r;
          quo_nxt = {quo_r[RC_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[RC_W-2:0], 1'b0};
        end
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RC_W - 1)) begin
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          push   = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    addr_r <= addr_nxt;
    spin_r <= spin_nxt;
    rnd_r  <= rnd_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign in_ready  = (st_r == F_IDLE);
  assign push_data = {kind_r, addr_r, quo_r, rem_r[RC_W-1:0], spin_r, rnd_r};

endmodule

// ===== rtl/core/imlu_back.sv =====
// back: runs loads, updates and measure walks on the lattice ram
module imlu_back import imlu_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int RC_W   = $clog2(MAX_SIDE),
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE),
  localparam int ENT_W  = 2 + ADDR_W + 2 * RC_W + 1 + RND_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_stat_t                q_stat,
  input  logic [ENT_W-1:0]       pop_data,
  output logic                   pop,
  input  logic [SIDE_W-1:0]      side_eff,
  input  logic [RND_W-1:0]       thr4,
  input  logic [RND_W-1:0]       thr8,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_addr,
  output logic                   ram_wdata,
  input  logic                   ram_q,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_accepted,
  output logic signed [DE_W-1:0] out_energy_change,
  output logic signed [EN_W-1:0] out_total_energy,
  output logic signed [MAG_W-1:0] out_magnetization_sum
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_UPD  = 4'b0010,
    B_MEAS = 4'b0100,
    B_DONE = 4'b1000
  } bst_t;

  // read phases: the site itself and its four neighbors
  localparam logic [2:0] PH_SELF = 3'd0;
  localparam logic [2:0] PH_UP   = 3'd1;
  localparam logic [2:0] PH_DN   = 3'd2;
  localparam logic [2:0] PH_LF   = 3'd3;
  localparam logic [2:0] PH_RT   = 3'd4;
  localparam logic [2:0] PH_END  = 3'd5;

  bst_t                    st_r, st_nxt;
  logic [ADDR_W-1:0]       addr_r, addr_nxt;
  logic [RC_W-1:0]         row_r, row_nxt, col_r, col_nxt;
  logic [RC_W-1:0]         mr_r, mr_nxt, mc_r, mc_nxt;
  logic                    spin_r, spin_nxt;
  logic [RND_W-1:0]        rnd_r, rnd_nxt;
  logic [2:0]              ph_r, ph_nxt;
  logic                    iss_r, iss_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [2:0]              rd_tag_r, rd_tag_nxt;
  logic                    rd_last_r, rd_last_nxt;
  logic                    sold_r, sold_nxt;
  logic [2:0]              cnt_r, cnt_nxt;
  logic                    s_self_r, s_self_nxt, s_rt_r, s_rt_nxt;
  logic signed [EN_W-1:0]  en_r, en_nxt;
  logic signed [MAG_W-1:0] mag_r, mag_nxt;
  logic                    wr_pend_r, wr_pend_nxt;
  logic                    res_acc_r, res_acc_nxt;
  logic signed [DE_W-1:0]  res_de_r, res_de_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_acc_r;
  logic signed [DE_W-1:0]  out_de_r;
  logic signed [EN_W-1:0]  out_en_r;
  logic signed [MAG_W-1:0] out_mag_r;
  logic                    out_load;

  logic [1:0]              e_kind_raw;
  kind_t                   e_kind;
  logic [ADDR_W-1:0]       e_addr;
  logic [RC_W-1:0]         e_row, e_col;
  logic                    e_spin;
  logic [RND_W-1:0]        e_rnd;

  logic [RC_W-1:0]         side_m1, cur_row, cur_col;
  logic [RC_W-1:0]         r_up, r_dn, c_lf, c_rt, sel_row, sel_col;
  logic [RC_W+SIDE_W-1:0]  addr_full;
  logic [2:0]              cnt_fin;
  logic signed [DE_W-1:0]  de_c;
  logic                    acc_c;
  logic                    eq_rt, eq_dn;

  assign {e_kind_raw, e_addr, e_row, e_col, e_spin, e_rnd} = pop_data;
  assign e_kind = kind_t'(e_kind_raw);

  // wrap-around neighbor rows and columns
  assign side_m1 = RC_W'(side_eff - 1'b1);
  assign cur_row = (st_r == B_MEAS) ? mr_r : row_r;
  assign cur_col = (st_r == B_MEAS) ? mc_r : col_r;
  assign r_up    = (cur_row == '0) ? side_m1 : RC_W'(cur_row - 1'b1);
  assign r_dn    = (cur_row == side_m1) ? '0 : RC_W'(cur_row + 1'b1);
  assign c_lf    = (cur_col == '0) ? side_m1 : RC_W'(cur_col - 1'b1);
  assign c_rt    = (cur_col == side_m1) ? '0 : RC_W'(cur_col + 1'b1);

  always_comb begin
    sel_row = cur_row;
    sel_col = cur_col;
    unique case (ph_r)
      PH_UP:   sel_row = r_up;
      PH_DN:   sel_row = r_dn;
      PH_LF:   sel_col = c_lf;
      PH_RT:   sel_col = c_rt;
      default: ;
    endcase
  end

  assign addr_full = sel_row * side_eff + (RC_W + SIDE_W)'(sel_col);
  assign ram_addr  = (st_r == B_DONE) ? addr_r : ADDR_W'(addr_full);
  assign ram_we    = (st_r == B_DONE) && wr_pend_r;
  assign ram_wdata = spin_r;

  // energy change from the count of plus neighbors
  assign cnt_fin = cnt_r + {2'b00, ram_q};
  always_comb begin
    if (spin_r == sold_r) begin
      de_c = '0;
    end else if (spin_r) begin
      de_c = DE_EIGHT - {cnt_fin, 2'b00};
    end else begin
      de_c = {cnt_fin, 2'b00} - DE_EIGHT;
    end
    if (de_c[DE_W-1] || de_c == '0) begin
      acc_c = 1'b1;
    end else if (de_c == DE_FOUR) begin
      acc_c = rnd_r < thr4;
    end else begin
      acc_c = rnd_r < thr8;
    end
  end

  assign eq_rt = (s_self_r == s_rt_r);
  assign eq_dn = (s_self_r == ram_q);

  always_comb begin
    st_nxt      = st_r;
    addr_nxt    = addr_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    mr_nxt      = mr_r;
    mc_nxt      = mc_r;
    spin_nxt    = spin_r;
    rnd_nxt     = rnd_r;
    ph_nxt      = ph_r;
    iss_nxt     = iss_r;
    rd_vld_nxt  = 1'b0;
    rd_tag_nxt  = rd_tag_r;
    rd_last_nxt = 1'b0;
    sold_nxt    = sold_r;
    cnt_nxt     = cnt_r;
    s_self_nxt  = s_self_r;
    s_rt_nxt    = s_rt_r;
    en_nxt      = en_r;
    mag_nxt     = mag_r;
    wr_pend_nxt = wr_pend_r;
    res_acc_nxt = res_acc_r;
    res_de_nxt  = res_de_r;
    pop         = 1'b0;
    out_load    = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop         = 1'b1;
          addr_nxt    = e_addr;
          row_nxt     = e_row;
          col_nxt     = e_col;
          spin_nxt    = e_spin;
          rnd_nxt     = e_rnd;
          en_nxt      = '0;
          mag_nxt     = '0;
          res_de_nxt  = '0;
          res_acc_nxt = 1'b0;
          wr_pend_nxt = 1'b0;
          cnt_nxt     = '0;
          ph_nxt      = PH_SELF;
          iss_nxt     = 1'b1;
          mr_nxt      = '0;
          mc_nxt      = '0;
          unique case (e_kind)
            K_NULL: st_nxt = B_DONE;
            K_LOAD: begin
              res_acc_nxt = 1'b1;
              wr_pend_nxt = 1'b1;
              st_nxt      = B_DONE;
            end
            K_UPDATE:  st_nxt = B_UPD;
            K_MEASURE: st_nxt = B_MEAS;
          endcase
        end
      end
      B_UPD: begin
        if (ph_r != PH_END) begin
          rd_vld_nxt = 1'b1;
          rd_tag_nxt = ph_r;
          ph_nxt     = ph_r + 3'd1;
        end
        if (rd_vld_r) begin
          if (rd_tag_r == PH_SELF) begin
            sold_nxt = ram_q;
          end else begin
            cnt_nxt = cnt_fin;
          end
          if (rd_tag_r == PH_RT) begin
            res_de_nxt  = de_c;
            res_acc_nxt = acc_c;
            wr_pend_nxt = acc_c;
            st_nxt      = B_DONE;
          end
        end
      end
      B_MEAS: begin
        if (iss_r) begin
          rd_vld_nxt  = 1'b1;
          rd_tag_nxt  = ph_r;
          rd_last_nxt = (ph_r == PH_DN) && (mr_r == side_m1) && (mc_r == side_m1);
          unique case (ph_r)
            PH_SELF: ph_nxt = PH_RT;
            PH_RT:   ph_nxt = PH_DN;
            default: begin
              ph_nxt = PH_SELF;
              if (mc_r == side_m1) begin
                mc_nxt = '0;
                if (mr_r == side_m1) begin
                  iss_nxt = 1'b0;
                end else begin
                  mr_nxt = RC_W'(mr_r + 1'b1);
                end
              end else begin
                mc_nxt = RC_W'(mc_r + 1'b1);
              end
            end
          endcase
        end
        if (rd_vld_r) begin
          unique case (rd_tag_r)
            PH_SELF: s_self_nxt = ram_q;
            PH_RT:   s_rt_nxt = ram_q;
            default: begin
              if (eq_rt && eq_dn) begin
                en_nxt = en_r - EN_W'(2);
              end else if (!eq_rt && !eq_dn) begin
                en_nxt = en_r + EN_W'(2);
              end
              mag_nxt = s_self_r ? mag_r + 1'b1 : mag_r - 1'b1;
              if (rd_last_r) begin
                st_nxt = B_DONE;
              end
            end
          endcase
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          st_nxt   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    mr_r      <= mr_nxt;
    mc_r      <= mc_nxt;
    spin_r    <= spin_nxt;
    rnd_r     <= rnd_nxt;
    ph_r      <= ph_nxt;
    iss_r     <= iss_nxt;
    rd_tag_r  <= rd_tag_nxt;
    sold_r    <= sold_nxt;
    cnt_r     <= cnt_nxt;
    s_self_r  <= s_self_nxt;
    s_rt_r    <= s_rt_nxt;
    en_r      <= en_nxt;
    mag_r     <= mag_nxt;
    wr_pend_r <= wr_pend_nxt;
    res_acc_r <= res_acc_nxt;
    res_de_r  <= res_de_nxt;
    if (out_load) begin
      out_acc_r <= res_acc_r;
      out_de_r  <= res_de_r;
      out_en_r  <= en_r;
      out_mag_r <= mag_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_accepted          = out_acc_r;
  assign out_energy_change     = out_de_r;
  assign out_total_energy      = out_en_r;
  assign out_magnetization_sum = out_mag_r;

endmodule

// ===== rtl/core/ising_metropolis_lattice_update_core.sv =====
// top level of the ising lattice metropolis update core
// The core holds a periodic square lattice of spins, one bit per site, in a
// single-port ram of MAX_SIDE*MAX_SIDE bits, and runs one command per input
// transfer: load a site, try a metropolis flip of a site, or measure the whole
// lattice. Every input transfer gives exactly one result transfer, in order.
// A front stage takes the transfer, checks the site against side*side and
// splits the site into row and column with a restoring divider of one bit a
// cycle, used only on an update. A two-entry queue carries the classified
// command to the back stage, which owns the ram port: an update makes the five
// serial reads of the site and its four wrap-around neighbors, then the
// decision and the write-back of an accepted flip; a measure makes three
// reads per site (the site, its right and its lower neighbor). The finished
// result sits in an output register, so front and back keep going while it
// waits to be taken. The front holds one command at a time, but takes the
// next while the back still works on earlier ones. Sites must be loaded before
// they are read; the ram has no reset. Configuration is to be written only
// while the core is idle; the core does not enforce this. The side in use is
// clamped to 3..MAX_SIDE.
module ising_metropolis_lattice_update_core import imlu_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int RC_W   = $clog2(MAX_SIDE),
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE),
  localparam int ENT_W  = 2 + ADDR_W + 2 * RC_W + 1 + RND_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  // command channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [SITE_W-1:0]       in_site,
  input  logic                    in_spin_bit,
  input  logic [RND_W-1:0]        in_random_word,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_accepted,
  output logic signed [DE_W-1:0]  out_energy_change,
  output logic signed [EN_W-1:0]  out_total_energy,
  output logic signed [MAG_W-1:0] out_magnetization_sum
);

  `include "ising_metropolis_lattice_update_core_assert.svh"

  logic [CFG_SIDE_W-1:0] side_r;
  logic [RND_W-1:0]      thr4_r, thr8_r;
  logic [SIDE_W-1:0]     side_eff;

  q_stat_t               q_stat;
  logic                  q_push, q_pop;
  logic [ENT_W-1:0]      q_push_data, q_pop_data;

  logic                  ram_we, ram_wdata, ram_q;
  logic [ADDR_W-1:0]     ram_addr;

  // config registers; thresholds keep all written bits, the side only the low CFG_SIDE_W
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RST;
      thr4_r <= THR4_RST;
      thr8_r <= THR8_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIDE: side_r <= cfg_wdata[CFG_SIDE_W-1:0];
        CFG_THR4: thr4_r <= cfg_wdata[RND_W-1:0];
        CFG_THR8: thr8_r <= cfg_wdata[RND_W-1:0];
        default:  ;
      endcase
    end
  end

  // side in use, clamped into 3..MAX_SIDE
  always_comb begin
    if (side_r < CFG_SIDE_W'(SIDE_MIN)) begin
      side_eff = SIDE_W'(SIDE_MIN);
    end else if (int'(side_r) > MAX_SIDE) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = SIDE_W'(side_r);
    end
  end

  // front: accept and classify, divide site into row and column
  imlu_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_site        (in_site),
    .in_spin_bit    (in_spin_bit),
    .in_random_word (in_random_word),
    .side_eff       (side_eff),
    .q_stat         (q_stat),
    .push           (q_push),
    .push_data      (q_push_data)
  );

  // decoupling queue between front and back
  imlu_queue #(
    .DATA_W (ENT_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .q_stat    (q_stat)
  );

  // back: sequences ram reads and writes, builds the result
  imlu_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_stat                (q_stat),
    .pop_data              (q_pop_data),
    .pop                   (q_pop),
    .side_eff              (side_eff),
    .thr4                  (thr4_r),
    .thr8                  (thr8_r),
    .ram_we                (ram_we),
    .ram_addr              (ram_addr),
    .ram_wdata             (ram_wdata),
    .ram_q                 (ram_q),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_accepted          (out_accepted),
    .out_energy_change     (out_energy_change),
    .out_total_energy      (out_total_energy),
    .out_magnetization_sum (out_magnetization_sum)
  );

  // lattice spins, one bit per site, row-major with the side in use
  imlu_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SIDE * MAX_SIDE)
  ) u_lattice (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  // front only pushes into a queue with room
  `IMLU_ASSERT_IMP(a_q_no_overflow, q_push, !q_stat.full)
  // energy changes come in steps of four
  `IMLU_ASSERT_IMP(a_de_step, out_valid, out_energy_change[1:0] == 2'b00)
  // an update result carries no lattice sums
  `IMLU_ASSERT_IMP(a_upd_no_sums, out_valid && (out_energy_change != '0),
    (out_total_energy == '0) && (out_magnetization_sum == '0))
  // front holds one command at a time
  `IMLU_ASSERT_NXT(a_front_busy, in_valid && in_ready, !in_ready)

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the ising lattice metropolis update core
`timescale 1ns / 100ps

module tb_top import imlu_pkg::*;;

  localparam int MAX_CELLS   = MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam int QUIET_LIMIT = 5000;   // cycles with no transfer on either channel
  localparam int HOLD_CYCLES = 300;    // long receiver back-pressure stretch
  localparam int DRAIN_TAIL  = 40;     // settle time after the last result
  localparam int RANDOM_ITEMS = 70;    // random commands per phase

  // mode 3 has no meaning in the core, it must come back as an all-zero result
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic                    accepted;
    logic signed [DE_W-1:0]  energy_change;
    logic signed [EN_W-1:0]  total_energy;
    logic signed [MAG_W-1:0] magnetization;
  } lattice_result_t;

  // predicts each result from its own copy of lattice and registers,
  // then compares every result transfer against the oldest prediction
  class lattice_scoreboard;
    bit                    spins [MAX_CELLS];
    logic [CFG_SIDE_W-1:0] side_reg;
    logic [RND_W-1:0]      thr_four;
    logic [RND_W-1:0]      thr_eight;
    lattice_result_t       expected_results [$];
    int                    errors;

    function new();
      side_reg  = SIDE_RST;
      thr_four  = THR4_RST;
      thr_eight = THR8_RST;
      errors    = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SIDE: side_reg  = data[CFG_SIDE_W-1:0];
        CFG_THR4: thr_four  = data;
        CFG_THR8: thr_eight = data;
        default: ;
      endcase
    endfunction

    function int side_used();
      int s;
      s = side_reg;
      if (s < SIDE_MIN) s = SIDE_MIN;
      if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
      return s;
    endfunction

    function int spin_of(int addr);
      return spins[addr] ? 1 : -1;
    endfunction

    function void note_command(logic [MODE_W-1:0] mode, logic [SITE_W-1:0] site_in,
                               logic spin_bit, logic [RND_W-1:0] draw);
      lattice_result_t res;
      int side, nsites, site, row, col, nsum, s_old, s_new, de, en, mag, i;
      side   = side_used();
      nsites = side * side;
      site   = site_in;
      res.accepted = 1'b0;
      de = 0;
      en = 0;
      mag = 0;
      case (mode)
        MODE_LOAD: begin
          if (site < nsites) begin
            spins[site]  = spin_bit;
            res.accepted = 1'b1;
          end
        end
        MODE_UPDATE: begin
          if (site < nsites) begin
            row  = site / side;
            col  = site % side;
            nsum = spin_of(((row + side - 1) % side) * side + col)
                 + spin_of(((row + 1) % side) * side + col)
                 + spin_of(row * side + (col + side - 1) % side)
                 + spin_of(row * side + (col + 1) % side);
            s_old = spin_of(site);
            s_new = spin_bit ? 1 : -1;
            de    = -(s_new - s_old) * nsum;
            if (de <= 0) res.accepted = 1'b1;
            else if (de == DE_FOUR) res.accepted = (draw < thr_four);
            else res.accepted = (draw < thr_eight);
            if (res.accepted) spins[site] = spin_bit;
          end
        end
        MODE_MEASURE: begin
          for (i = 0; i < nsites; i++) begin
            row = i / side;
            col = i % side;
            en -= spin_of(i) * (spin_of(row * side + (col + 1) % side)
                              + spin_of(((row + 1) % side) * side + col));
            mag += spin_of(i);
          end
        end
        default: ;
      endcase
      res.energy_change = de[DE_W-1:0];
      res.total_energy  = en[EN_W-1:0];
      res.magnetization = mag[MAG_W-1:0];
      expected_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(lattice_result_t got);
      lattice_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
        return;
      end
      want = expected_results.pop_front();
      if (got.accepted !== want.accepted)
        report_mismatch($sformatf("accepted got %0d want %0d", got.accepted, want.accepted));
      if (got.energy_change !== want.energy_change)
        report_mismatch($sformatf("energy_change got %0d want %0d",
                                  got.energy_change, want.energy_change));
      if (got.total_energy !== want.total_energy)
        report_mismatch($sformatf("total_energy got %0d want %0d",
                                  got.total_energy, want.total_energy));
      if (got.magnetization !== want.magnetization)
        report_mismatch($sformatf("magnetization_sum got %0d want %0d",
                                  got.magnetization, want.magnetization));
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic [MODE_W-1:0]       in_mode;
  logic [SITE_W-1:0]       in_site;
  logic                    in_spin_bit;
  logic [RND_W-1:0]        in_random_word;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_accepted;
  logic signed [DE_W-1:0]  out_energy_change;
  logic signed [EN_W-1:0]  out_total_energy;
  logic signed [MAG_W-1:0] out_magnetization_sum;

  lattice_scoreboard sb = new();

  // stimulus-side view of the core: which sites hold a loaded spin, and the
  // side and thresholds in force, so that no never-written site gets read
  bit              loaded [MAX_CELLS];
  int              side_eff = MAX_SIDE_DEF;
  logic [RND_W-1:0] thr4_now = THR4_RST;
  logic [RND_W-1:0] thr8_now = THR8_RST;

  // idle rates in percent per cycle, changed between phases
  int send_idle_pct;
  int recv_idle_pct;

  // receiver back-pressure request and its countdown
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  ising_metropolis_lattice_update_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_site               (in_site),
    .in_spin_bit           (in_spin_bit),
    .in_random_word        (in_random_word),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_accepted          (out_accepted),
    .out_energy_change     (out_energy_change),
    .out_total_energy      (out_total_energy),
    .out_magnetization_sum (out_magnetization_sum)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random ready at the falling edge, or a long counted hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: both channels sampled at the rising edge, plus the watchdog
  always @(posedge clk) begin
    lattice_result_t got;
    if (rst_n) begin
      // command transfer feeds the predictor in acceptance order
      if (in_valid && in_ready)
        sb.note_command(in_mode, in_site, in_spin_bit, in_random_word);
      // result transfer checked against the oldest prediction
      if (out_valid && out_ready) begin
        got.accepted      = out_accepted;
        got.energy_change = out_energy_change;
        got.total_energy  = out_total_energy;
        got.magnetization = out_magnetization_sum;
        sb.check_result(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  // one command transfer; entered and left at a falling edge
  task automatic send_command(logic [MODE_W-1:0] mode, int site, logic spin_bit,
                              logic [RND_W-1:0] draw);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_site        <= site[SITE_W-1:0];
    in_spin_bit    <= spin_bit;
    in_random_word <= draw;
    // an out-of-range load leaves the site unwritten
    if (mode == MODE_LOAD && site < side_eff * side_eff) loaded[site] = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  // register write, only called while the core is idle
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.apply_register(idx, data);
    case (idx)
      CFG_SIDE: begin
        side_eff = int'(data[CFG_SIDE_W-1:0]);
        if (side_eff < SIDE_MIN) side_eff = SIDE_MIN;
        if (side_eff > MAX_SIDE_DEF) side_eff = MAX_SIDE_DEF;
      end
      CFG_THR4: thr4_now = data;
      CFG_THR8: thr8_now = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // acceptance draw, often right at or just below a threshold
  function automatic logic [RND_W-1:0] pick_draw();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return thr4_now - $urandom_range(1);
      3: return thr8_now - $urandom_range(1);
      default: return $urandom;
    endcase
  endfunction

  // site and its four wrap-around neighbors all hold loaded spins
  function automatic bit update_safe(int site);
    int row, col;
    row = site / side_eff;
    col = site % side_eff;
    return loaded[site]
        && loaded[((row + side_eff - 1) % side_eff) * side_eff + col]
        && loaded[((row + 1) % side_eff) * side_eff + col]
        && loaded[row * side_eff + (col + side_eff - 1) % side_eff]
        && loaded[row * side_eff + (col + 1) % side_eff];
  endfunction

  function automatic bit measure_safe(int nsites);
    for (int i = 0; i < nsites; i++)
      if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  // load sites 0 .. count-1, up_pct percent of them as spin up
  task automatic fill_sites(int count, int up_pct);
    for (int i = 0; i < count; i++)
      send_command(MODE_LOAD, i, ($urandom_range(99) < up_pct), $urandom);
  endtask

  // mostly legal updates, with loads, measures, out-of-range sites and mode 3
  task automatic run_random(int count);
    int pick, site, nsites, tries;
    for (int k = 0; k < count; k++) begin
      nsites = side_eff * side_eff;
      pick   = $urandom_range(99);
      if (pick < 60) begin
        site  = $urandom_range(nsites - 1);
        tries = 0;
        while (!update_safe(site) && tries < 20) begin
          site = $urandom_range(nsites - 1);
          tries++;
        end
        // on the big lattice only the loaded band is safe: use its middle row
        if (!update_safe(site)) site = side_eff + $urandom_range(side_eff - 1);
        send_command(MODE_UPDATE, site, $urandom_range(1), pick_draw());
      end else if (pick < 84 && pick >= 78 && measure_safe(nsites)) begin
        send_command(MODE_MEASURE, $urandom_range(4095), $urandom_range(1), $urandom);
      end else if (pick < 84) begin
        send_command(MODE_LOAD, $urandom_range(nsites - 1), $urandom_range(1), $urandom);
      end else if (pick < 94 && nsites < MAX_CELLS) begin
        // site beyond side*side: no change, all-zero result
        send_command($urandom_range(1) ? MODE_UPDATE : MODE_LOAD,
                     $urandom_range(4095, nsites), $urandom_range(1), pick_draw());
      end else begin
        send_command(MODE_UNUSED, $urandom_range(4095), $urandom_range(1), $urandom);
      end
    end
  endtask

  // one setting of the registers, a fresh load of the lattice, then random traffic
  task automatic run_phase(logic [CFG_DATA_W-1:0] side_val, logic [RND_W-1:0] t4,
                           logic [RND_W-1:0] t8, int fill_count, int up_pct,
                           int count, bit with_hold);
    drain();
    set_register(CFG_SIDE, side_val);
    set_register(CFG_THR4, t4);
    set_register(CFG_THR8, t8);
    // the sender keeps offering while the receiver holds off
    if (with_hold) hold_req = 1'b1;
    fill_sites(fill_count, up_pct);
    run_random(count);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SIDE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_mode        = MODE_LOAD;
    in_site        = '0;
    in_spin_bit    = 1'b0;
    in_random_word = '0;
    out_ready      = 1'b0;
    hold_req       = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 15;
    recv_idle_pct  = 82;

    // reset held from the start, released at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset registers (side 64): site 65 has neighbors 1, 64, 66, 129
    send_command(MODE_UNUSED, 4095, 1'b1, '1);
    send_command(MODE_LOAD, 1, 1'b1, $urandom);
    send_command(MODE_LOAD, 64, 1'b1, $urandom);
    send_command(MODE_LOAD, 66, 1'b1, $urandom);
    send_command(MODE_LOAD, 129, 1'b1, $urandom);
    send_command(MODE_LOAD, 65, 1'b0, $urandom);
    // same spin proposed again: zero change, accepted
    send_command(MODE_UPDATE, 65, 1'b0, $urandom);
    // down to up among four up neighbors: always taken, even with the top draw
    send_command(MODE_UPDATE, 65, 1'b1, '1);
    // back down costs 8, top draw rejects
    send_command(MODE_UPDATE, 65, 1'b0, '1);
    send_command(MODE_LOAD, 1, 1'b0, $urandom);
    // cost 4 with the draw equal to the threshold, then one below it
    send_command(MODE_UPDATE, 65, 1'b0, THR4_RST);
    send_command(MODE_UPDATE, 65, 1'b0, THR4_RST - 1);
    send_command(MODE_UPDATE, 65, 1'b1, $urandom);
    send_command(MODE_LOAD, 4095, 1'b1, '0);

    // directed, side 0 clamps to 3, thresholds at their extremes, all spins up
    run_phase(32'd0, '0, '1, 9, 100, 0, 1'b0);
    send_command(MODE_MEASURE, 0, 1'b0, '0);
    // cost 8 with the draw at the full-scale threshold: strict compare rejects
    send_command(MODE_UPDATE, 4, 1'b0, '1);
    send_command(MODE_UPDATE, 4095, 1'b1, '0);
    send_command(MODE_LOAD, 9, 1'b1, '1);

    // sender mostly busy, receiver mostly stalled
    run_phase(32'd4, $urandom, $urandom, 16, 50, RANDOM_ITEMS, 1'b0);
    run_phase(32'd1, $urandom, $urandom, 9, 100, RANDOM_ITEMS, 1'b0);
    run_phase(32'd7, $urandom, $urandom, 49, 50, RANDOM_ITEMS, 1'b0);

    // roles swapped; first phase also gets the long receiver hold-off
    send_idle_pct = 82;
    recv_idle_pct = 15;
    run_phase(32'd11, '0, '0, 121, 85, RANDOM_ITEMS, 1'b1);
    run_phase(32'd5, '1, '1, 25, 0, RANDOM_ITEMS, 1'b0);
    // full-size lattice: only rows 0 to 2 loaded, updates stay on row 1
    run_phase(32'd64, $urandom, $urandom, 3 * MAX_SIDE_DEF, 60, RANDOM_ITEMS, 1'b0);

    // no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // all seven side bits set plus junk above them: clamps to the maximum side
    run_phase(($urandom & ~32'h7F) | 32'h7F, $urandom, $urandom, 0, 50, RANDOM_ITEMS, 1'b0);
    run_phase(32'd9, $urandom, $urandom, 81, 50, RANDOM_ITEMS, 1'b0);
    run_phase(32'd3, $urandom, $urandom, 9, 30, RANDOM_ITEMS, 1'b0);

    drain();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
